// File: sv/assert_macros.svh
// Assertion macros used by the port-level checker of this block.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// File: sv/wta_pkg.sv
// Shared constants, codes and helper functions of the wheel torque allocator.
// Used by the top level and by its checker; depends on nothing.
`default_nettype none

package wta_pkg;

	localparam int MAX_WHEELS_DEF = 8;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_BUILD = 2'd1;
	localparam logic [1:0] OP_ALLOC = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_COPLANAR  = 2'd1;
	localparam logic [1:0] ST_NOT_BUILT = 2'd2;

	localparam logic [1:0] REG_MAX_TORQUE  = 2'd0;
	localparam logic [1:0] REG_WHEEL_COUNT = 2'd1;

	localparam logic [22:0] MAX_TORQUE_RST  = 23'd13107;
	localparam logic [3:0]  WHEEL_COUNT_RST = 4'd3;
	localparam logic signed [15:0] ONE_Q14 = 16'sd16384;
	localparam logic signed [23:0] ONE_Q16 = 24'sd65536;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_MUL  = 5'b00010,
		S_ACC  = 5'b00100,
		S_DIVI = 5'b01000,
		S_DIV  = 5'b10000
	} state_t;

	typedef enum logic [4:0] {
		K_M     = 5'b00001,
		K_ADJ   = 5'b00010,
		K_DET   = 5'b00100,
		K_ROW   = 5'b01000,
		K_ALLOC = 5'b10000
	} kind_t;

	// Round to nearest, ties away from zero, then drop s fraction bits.
	function automatic logic signed [63:0] rnd(input logic signed [63:0] v,
			input logic [5:0] s);
		logic [63:0] mag;
		logic [63:0] r;
		mag = v[63] ? 64'(-v) : 64'(v);
		r = (mag + (64'd1 << (s - 6'd1))) >> s;
		rnd = v[63] ? -$signed(r) : $signed(r);
	endfunction

	// Row and column of a matrix element numbered in row-major order.
	function automatic logic [1:0] e_row(input logic [3:0] e);
		if (e < 4'd3) e_row = 2'd0;
		else if (e < 4'd6) e_row = 2'd1;
		else e_row = 2'd2;
	endfunction

	function automatic logic [1:0] e_col(input logic [3:0] e);
		if (e < 4'd3) e_col = 2'(e);
		else if (e < 4'd6) e_col = 2'(e - 4'd3);
		else e_col = 2'(e - 4'd6);
	endfunction

	// Cofactor operands {a0, b0, a1, b1}: adj[e] = m[a0]*m[b0] - m[a1]*m[b1].
	function automatic logic [15:0] adj_sel(input logic [3:0] e);
		unique case (e)
			4'd0: adj_sel = {4'd4, 4'd8, 4'd5, 4'd7};
			4'd1: adj_sel = {4'd2, 4'd7, 4'd1, 4'd8};
			4'd2: adj_sel = {4'd1, 4'd5, 4'd2, 4'd4};
			4'd3: adj_sel = {4'd5, 4'd6, 4'd3, 4'd8};
			4'd4: adj_sel = {4'd0, 4'd8, 4'd2, 4'd6};
			4'd5: adj_sel = {4'd2, 4'd3, 4'd0, 4'd5};
			4'd6: adj_sel = {4'd3, 4'd7, 4'd4, 4'd6};
			4'd7: adj_sel = {4'd1, 4'd6, 4'd0, 4'd7};
			4'd8: adj_sel = {4'd0, 4'd4, 4'd1, 4'd3};
			default: adj_sel = 16'd0;
		endcase
	endfunction

endpackage

`default_nettype wire

// File: sv/wheel_torque_allocator_unit.sv
// Reaction wheel torque allocator: axis table, pseudoinverse build and allocation.
// Depends on wta_pkg; one shared 32x32 multiply-accumulate and a radix-2 divider.
// Load axis: stores the axis, no result. Allocate: products in turn on the shared
// multiplier, one wheel torque for each of the n wheels, and the unit stays busy until
// the last; not_built comes the cycle after the item. Build: matrix, cofactors,
// determinant, nine divides and two row passes, with the unit busy throughout;
// its status comes at the end. Results cannot be held off by the receiver.
// Reset loads unit axes and identity rows for wheels 0 to 2, valid solution, defaults.
`default_nettype none

module wheel_torque_allocator_unit #(
	parameter int MAX_WHEELS = wta_pkg::MAX_WHEELS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         opcode,
	input  wire logic [2:0]         wheel_index,
	input  wire logic signed [15:0] axis_x,
	input  wire logic signed [15:0] axis_y,
	input  wire logic signed [15:0] axis_z,
	input  wire logic signed [23:0] torque_x,
	input  wire logic signed [23:0] torque_y,
	input  wire logic signed [23:0] torque_z,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [22:0]        cfg_data,
	output logic                    strobe,
	output logic [1:0]              status,
	output logic [2:0]              result_wheel,
	output logic signed [23:0]      wheel_torque,
	output logic                    clamped,
	output logic                    last
);
	import wta_pkg::*;

	localparam int IDX_W = $clog2(MAX_WHEELS);
	localparam int CNT_W = $clog2(MAX_WHEELS + 1);
	localparam int M_W   = 20 + $clog2(MAX_WHEELS);

	logic signed [15:0] axis_q [MAX_WHEELS][3];
	logic signed [23:0] pinv_q [MAX_WHEELS][3];
	logic               valid_q;
	logic [22:0]        max_torque_q;
	logic [3:0]         wheel_count_q;

	state_t             state_q;
	kind_t              kind_q;
	logic               pass_q;
	logic [3:0]         e_q;
	logic [IDX_W-1:0]   i_q;
	logic [IDX_W-1:0]   t_q;

	logic signed [63:0] acc_q;
	logic signed [63:0] p_q;
	logic               sub_q;
	logic signed [M_W-1:0] m_q [9];
	logic signed [31:0] adj_q [9];
	logic signed [31:0] inv_q [9];
	logic signed [63:0] det_q;
	logic signed [23:0] tq_q [3];
	logic [64:0]        rem_q;
	logic [95:0]        dvs_q;
	logic [31:0]        quo_q;
	logic [4:0]         bit_q;

	logic               strobe_q;
	logic [1:0]         status_q;
	logic [2:0]         wheel_q;
	logic signed [23:0] torque_q;
	logic               clamped_q;
	logic               last_q;

	logic               accept;
	logic [CNT_W-1:0]   n_use;
	logic               t_last;
	logic               i_last;
	logic signed [31:0] op_a;
	logic signed [31:0] op_b;
	logic               op_sub;
	logic signed [63:0] prod;
	logic signed [63:0] sum;
	logic signed [63:0] row_v;
	logic               row_ovf;
	logic signed [63:0] alloc_v;
	logic signed [63:0] lim;
	logic signed [23:0] clamp_v;
	logic               clamp_hit;
	logic [3:0]         idx3;
	logic [15:0]        asel;
	logic [31:0]        mag_adj;
	logic [63:0]        dm;
	logic               ge;
	logic [31:0]        q_next;
	logic signed [31:0] inv_v;
	logic               fail;
	logic               succ;
	logic               em;
	logic [1:0]         em_st;
	logic [2:0]         em_wh;
	logic signed [23:0] em_tq;
	logic               em_cl;
	logic               em_last;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);
	assign prod   = op_a * op_b;
	assign sum    = acc_q + (sub_q ? -p_q : p_q);
	assign idx3   = {2'b00, t_q[1:0]} + {1'b0, t_q[1:0], 1'b0};
	assign asel   = adj_sel(e_q);

	always_comb begin
		if (wheel_count_q == 4'd0) n_use = CNT_W'(1);
		else if (int'(wheel_count_q) > MAX_WHEELS) n_use = CNT_W'(MAX_WHEELS);
		else n_use = CNT_W'(wheel_count_q);
	end

	assign i_last = (i_q == IDX_W'(n_use - 1'b1));

	// Operand selection for the shared multiplier, by phase and term.
	always_comb begin
		op_a   = '0;
		op_b   = '0;
		op_sub = 1'b0;
		t_last = (t_q == IDX_W'(2));
		unique case (kind_q)
			K_M: begin
				op_a   = 32'(axis_q[t_q][e_row(e_q)]);
				op_b   = 32'(axis_q[t_q][e_col(e_q)]);
				t_last = (t_q == IDX_W'(n_use - 1'b1));
			end
			K_ADJ: begin
				op_a   = t_q[0] ? 32'(m_q[asel[7:4]]) : 32'(m_q[asel[15:12]]);
				op_b   = t_q[0] ? 32'(m_q[asel[3:0]]) : 32'(m_q[asel[11:8]]);
				op_sub = t_q[0];
				t_last = (t_q == IDX_W'(1));
			end
			K_DET: begin
				op_a = 32'(m_q[4'(t_q[1:0])]);
				op_b = adj_q[idx3];
			end
			K_ROW: begin
				op_a = 32'(axis_q[i_q][t_q[1:0]]);
				op_b = inv_q[idx3 + e_q];
			end
			K_ALLOC: begin
				op_a = 32'(pinv_q[i_q][t_q[1:0]]);
				op_b = 32'(tq_q[t_q[1:0]]);
			end
			default: begin
				op_a = '0;
			end
		endcase
	end

	always_comb begin
		row_v   = rnd(sum, 6'd14);
		row_ovf = (row_v > 64'sd8388607) || (row_v < -64'sd8388608);
		alloc_v = rnd(sum, 6'd16);
		lim     = $signed({41'b0, max_torque_q});
		clamp_hit = 1'b1;
		if (alloc_v > lim) clamp_v = 24'(lim);
		else if (alloc_v < -lim) clamp_v = 24'(-lim);
		else begin
			clamp_v   = 24'(alloc_v);
			clamp_hit = 1'b0;
		end
	end

	// Divider step: quotient bit for the current divisor position.
	always_comb begin
		mag_adj = adj_q[e_q][31] ? 32'(-adj_q[e_q]) : 32'(adj_q[e_q]);
		dm      = det_q[63] ? 64'(-det_q) : 64'(det_q);
		ge      = ({31'b0, rem_q} >= dvs_q);
		q_next  = quo_q | (32'(ge) << bit_q);
		inv_v   = (adj_q[e_q][31] ^ det_q[63]) ? -$signed(q_next) : $signed(q_next);
	end

	always_comb begin
		fail    = 1'b0;
		succ    = 1'b0;
		em      = 1'b0;
		em_st   = ST_OK;
		em_wh   = 3'd0;
		em_tq   = '0;
		em_cl   = 1'b0;
		em_last = 1'b1;
		if (accept && (opcode == OP_ALLOC) && !valid_q) begin
			em    = 1'b1;
			em_st = ST_NOT_BUILT;
		end
		if ((state_q == S_ACC) && t_last) begin
			if ((kind_q == K_DET) && (sum == 64'sd0)) fail = 1'b1;
			if ((kind_q == K_ROW) && !pass_q && row_ovf) fail = 1'b1;
			if ((kind_q == K_ROW) && pass_q && (e_q == 4'd2) && i_last) succ = 1'b1;
			if (kind_q == K_ALLOC) begin
				em      = 1'b1;
				em_wh   = 3'(i_q);
				em_tq   = clamp_v;
				em_cl   = clamp_hit;
				em_last = i_last;
			end
		end
		// A quotient of 2^31 or more does not fit the inverse format.
		if ((state_q == S_DIV) && (bit_q == 5'd0) && q_next[31]) fail = 1'b1;
		if (fail) begin
			em    = 1'b1;
			em_st = ST_COPLANAR;
		end
		if (succ) em = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < MAX_WHEELS; w++) begin
				for (int k = 0; k < 3; k++) begin
					axis_q[w][k] <= (w == k) ? ONE_Q14 : '0;
					pinv_q[w][k] <= (w == k) ? ONE_Q16 : '0;
				end
			end
			valid_q       <= 1'b1;
			max_torque_q  <= MAX_TORQUE_RST;
			wheel_count_q <= WHEEL_COUNT_RST;
			state_q       <= S_IDLE;
			kind_q        <= K_M;
			pass_q        <= 1'b0;
			e_q           <= '0;
			i_q           <= '0;
			t_q           <= '0;
			strobe_q      <= 1'b0;
		end else begin
			strobe_q <= em;
			if (cfg_we) begin
				if (cfg_index == REG_MAX_TORQUE) max_torque_q <= cfg_data;
				else if (cfg_index == REG_WHEEL_COUNT) begin
					wheel_count_q <= cfg_data[3:0];
					valid_q       <= 1'b0;
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						e_q <= '0;
						i_q <= '0;
						t_q <= '0;
						if (opcode == OP_LOAD) begin
							if (int'(wheel_index) < MAX_WHEELS) begin
								axis_q[IDX_W'(wheel_index)][0] <= axis_x;
								axis_q[IDX_W'(wheel_index)][1] <= axis_y;
								axis_q[IDX_W'(wheel_index)][2] <= axis_z;
								valid_q <= 1'b0;
							end
						end else if (opcode == OP_BUILD) begin
							kind_q  <= K_M;
							state_q <= S_MUL;
						end else if ((opcode == OP_ALLOC) && valid_q) begin
							kind_q  <= K_ALLOC;
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					state_q <= S_MUL;
					if (!t_last) begin
						t_q <= t_q + 1'b1;
					end else begin
						t_q <= '0;
						if (fail) begin
							state_q <= S_IDLE;
							valid_q <= 1'b0;
						end else begin
							unique case (kind_q)
								K_M: begin
									if (e_q == 4'd8) begin
										kind_q <= K_ADJ;
										e_q    <= '0;
									end else e_q <= e_q + 1'b1;
								end
								K_ADJ: begin
									if (e_q == 4'd8) begin
										kind_q <= K_DET;
										e_q    <= '0;
									end else e_q <= e_q + 1'b1;
								end
								K_DET: begin
									state_q <= S_DIVI;
									e_q     <= '0;
								end
								K_ROW: begin
									if (pass_q) pinv_q[i_q][e_q[1:0]] <= 24'(row_v);
									if (e_q != 4'd2) e_q <= e_q + 1'b1;
									else begin
										e_q <= '0;
										if (!i_last) i_q <= i_q + 1'b1;
										else if (!pass_q) begin
											// Checked pass done: clear the table and write it.
											pass_q <= 1'b1;
											i_q    <= '0;
											for (int w = 0; w < MAX_WHEELS; w++) begin
												for (int k = 0; k < 3; k++) pinv_q[w][k] <= '0;
											end
										end else begin
											valid_q <= 1'b1;
											state_q <= S_IDLE;
										end
									end
								end
								K_ALLOC: begin
									if (i_last) state_q <= S_IDLE;
									else i_q <= i_q + 1'b1;
								end
								default: begin
									state_q <= S_IDLE;
								end
							endcase
						end
					end
				end
				S_DIVI: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (bit_q == 5'd0) begin
						if (fail) begin
							state_q <= S_IDLE;
							valid_q <= 1'b0;
						end else if (e_q == 4'd8) begin
							kind_q  <= K_ROW;
							pass_q  <= 1'b0;
							e_q     <= '0;
							i_q     <= '0;
							t_q     <= '0;
							state_q <= S_MUL;
						end else begin
							e_q     <= e_q + 1'b1;
							state_q <= S_DIVI;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				acc_q <= '0;
				if (accept && (opcode == OP_ALLOC)) begin
					tq_q[0] <= torque_x;
					tq_q[1] <= torque_y;
					tq_q[2] <= torque_z;
				end
			end
			S_MUL: begin
				p_q   <= prod;
				sub_q <= op_sub;
			end
			S_ACC: begin
				acc_q <= t_last ? 64'sd0 : sum;
				if (t_last) begin
					if (kind_q == K_M) m_q[e_q] <= M_W'(rnd(sum, 6'd12));
					if (kind_q == K_ADJ) adj_q[e_q] <= 32'(rnd(sum, 6'd16));
					if (kind_q == K_DET) det_q <= sum;
				end
			end
			S_DIVI: begin
				rem_q <= {1'b0, mag_adj, 32'b0} + 65'(dm >> 1);
				dvs_q <= {1'b0, dm, 31'b0};
				quo_q <= '0;
				bit_q <= 5'd31;
			end
			S_DIV: begin
				if (ge) rem_q <= rem_q - dvs_q[64:0];
				dvs_q <= dvs_q >> 1;
				quo_q <= q_next;
				bit_q <= bit_q - 1'b1;
				if (bit_q == 5'd0) inv_q[e_q] <= inv_v;
			end
			default: begin
				acc_q <= '0;
			end
		endcase
		if (em) begin
			status_q  <= em_st;
			wheel_q   <= em_wh;
			torque_q  <= em_tq;
			clamped_q <= em_cl;
			last_q    <= em_last;
		end
	end

	assign strobe       = strobe_q;
	assign status       = status_q;
	assign result_wheel = wheel_q;
	assign wheel_torque = torque_q;
	assign clamped      = clamped_q;
	assign last         = last_q;

endmodule

`default_nettype wire

// File: sv/wta_checker.sv
// Port-level checks of the wheel torque allocator, bound to its top level.
// Depends on wta_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module wta_props (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               start,
	input wire logic               busy,
	input wire logic [1:0]         opcode,
	input wire logic               strobe,
	input wire logic [1:0]         status,
	input wire logic [2:0]         result_wheel,
	input wire logic signed [23:0] wheel_torque,
	input wire logic               clamped,
	input wire logic               last
);
	import wta_pkg::*;

	// A status item carries no torque and always closes its item.
	`ASSERT_IMPL(a_status_clean, clk, arst_n, strobe && (status != ST_OK), (wheel_torque == 24'sd0) && !clamped && (result_wheel == 3'd0) && last)
	`ASSERT_IMPL(a_status_code, clk, arst_n, strobe, status != 2'd3)
	// A build that is taken always makes the unit busy.
	`ASSERT_NEXT(a_build_busy, clk, arst_n, start && !busy && (opcode == OP_BUILD), busy)
	// More wheel torques are still to come after a non-final item.
	`ASSERT_NEXT(a_more_results, clk, arst_n, strobe && !last, busy)

endmodule

bind wheel_torque_allocator_unit wta_props u_wta_props (.*);

`default_nettype wire

// File: tb/wta_checker.sv
// Checker for the wheel torque allocator: watches items, register writes and results.
// Predicts every result from its own copy of the axis and pseudoinverse tables.
// Depends on wta_pkg for the operation, status and register codes and the reset values.
`timescale 1ns / 1ps

module wta_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic               busy,
	input  wire logic [1:0]         opcode,
	input  wire logic [2:0]         wheel_index,
	input  wire logic signed [15:0] axis_x,
	input  wire logic signed [15:0] axis_y,
	input  wire logic signed [15:0] axis_z,
	input  wire logic signed [23:0] torque_x,
	input  wire logic signed [23:0] torque_y,
	input  wire logic signed [23:0] torque_z,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [22:0]        cfg_data,
	input  wire logic               strobe,
	input  wire logic [1:0]         status,
	input  wire logic [2:0]         result_wheel,
	input  wire logic signed [23:0] wheel_torque,
	input  wire logic               clamped,
	input  wire logic               last,
	output int                      fail_count,
	output int                      pending
);
	import wta_pkg::*;

	localparam int NWHEEL = 8;

	typedef struct {
		logic [1:0]         st;
		logic [2:0]         wheel;
		logic signed [23:0] torque;
		logic               clip;
		logic               fin;
	} wheel_result_t;

	wheel_result_t torque_q[$];
	longint axes[NWHEEL][3];
	longint rows[NWHEEL][3];
	bit     rows_ok;
	logic [22:0] torque_limit;
	logic [3:0]  count_reg;

	assign pending = torque_q.size();

	function automatic longint round_drop(longint v, int s);
		longint unsigned mag;
		longint unsigned r;
		mag = (v < 0) ? longint'(-v) : longint'(v);
		r = (mag + (64'd1 << (s - 1))) >> s;
		return (v < 0) ? -longint'(r) : longint'(r);
	endfunction

	function automatic int active_wheels();
		if (count_reg == 4'd0) return 1;
		if (count_reg > NWHEEL) return NWHEEL;
		return int'(count_reg);
	endfunction

	function automatic void reset_tables();
		for (int i = 0; i < NWHEEL; i++)
			for (int c = 0; c < 3; c++) begin
				axes[i][c] = (i == c) ? 16384 : 0;
				rows[i][c] = (i == c) ? 65536 : 0;
			end
		rows_ok = 1;
		torque_limit = MAX_TORQUE_RST;
		count_reg = WHEEL_COUNT_RST;
	endfunction

	// Forms W*W^T, inverts it by cofactors and stores the new rows on success.
	function automatic bit solve_rows();
		int n;
		longint m[3][3];
		longint adj[3][3];
		longint inv[3][3];
		longint nrow[NWHEEL][3];
		longint acc;
		longint det;
		longint unsigned dm;
		longint unsigned q;
		longint unsigned num;
		n = active_wheels();
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++) begin
				acc = 0;
				for (int i = 0; i < n; i++) acc += axes[i][r] * axes[i][c];
				m[r][c] = round_drop(acc, 12);
			end
		adj[0][0] = m[1][1]*m[2][2] - m[1][2]*m[2][1];
		adj[0][1] = m[0][2]*m[2][1] - m[0][1]*m[2][2];
		adj[0][2] = m[0][1]*m[1][2] - m[0][2]*m[1][1];
		adj[1][0] = m[1][2]*m[2][0] - m[1][0]*m[2][2];
		adj[1][1] = m[0][0]*m[2][2] - m[0][2]*m[2][0];
		adj[1][2] = m[0][2]*m[1][0] - m[0][0]*m[1][2];
		adj[2][0] = m[1][0]*m[2][1] - m[1][1]*m[2][0];
		adj[2][1] = m[0][1]*m[2][0] - m[0][0]*m[2][1];
		adj[2][2] = m[0][0]*m[1][1] - m[0][1]*m[1][0];
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++) adj[r][c] = round_drop(adj[r][c], 16);
		det = m[0][0]*adj[0][0] + m[0][1]*adj[1][0] + m[0][2]*adj[2][0];
		if (det == 0) return 0;
		dm = (det < 0) ? longint'(-det) : longint'(det);
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++) begin
				num = ((adj[r][c] < 0) ? longint'(-adj[r][c]) : longint'(adj[r][c])) << 32;
				q = (num + (dm >> 1)) / dm;
				if (q > 64'd2147483647) return 0;
				inv[r][c] = ((adj[r][c] < 0) != (det < 0)) ? -longint'(q) : longint'(q);
			end
		for (int i = 0; i < NWHEEL; i++)
			for (int c = 0; c < 3; c++) nrow[i][c] = 0;
		for (int i = 0; i < n; i++)
			for (int c = 0; c < 3; c++) begin
				acc = 0;
				for (int k = 0; k < 3; k++) acc += axes[i][k] * inv[k][c];
				acc = round_drop(acc, 14);
				if (acc > 8388607 || acc < -8388608) return 0;
				nrow[i][c] = acc;
			end
		rows = nrow;
		return 1;
	endfunction

	function automatic void push_result(logic [1:0] st, int w, longint tq, bit cl, bit fin);
		wheel_result_t e;
		e.st = st;
		e.wheel = 3'(w);
		e.torque = 24'(tq);
		e.clip = cl;
		e.fin = fin;
		torque_q.push_back(e);
	endfunction

	function automatic void predict_item();
		int n;
		longint acc;
		longint lim;
		bit cl;
		n = active_wheels();
		lim = longint'(torque_limit);
		case (opcode)
			OP_LOAD: begin
				axes[wheel_index][0] = longint'(axis_x);
				axes[wheel_index][1] = longint'(axis_y);
				axes[wheel_index][2] = longint'(axis_z);
				rows_ok = 0;
			end
			OP_BUILD: begin
				rows_ok = solve_rows();
				push_result(rows_ok ? ST_OK : ST_COPLANAR, 0, 0, 0, 1);
			end
			OP_ALLOC: begin
				if (!rows_ok) push_result(ST_NOT_BUILT, 0, 0, 0, 1);
				else
					for (int i = 0; i < n; i++) begin
						acc = rows[i][0] * longint'(torque_x) + rows[i][1] * longint'(torque_y)
							+ rows[i][2] * longint'(torque_z);
						acc = round_drop(acc, 16);
						cl = 0;
						if (acc > lim) begin
							acc = lim;
							cl = 1;
						end else if (acc < -lim) begin
							acc = -lim;
							cl = 1;
						end
						push_result(ST_OK, i, acc, cl, i + 1 == n);
					end
			end
			default: ;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		wheel_result_t e;
		if (!arst_n) begin
			reset_tables();
			torque_q.delete();
			fail_count <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_MAX_TORQUE) torque_limit = cfg_data;
				else if (cfg_index == REG_WHEEL_COUNT) begin
					count_reg = cfg_data[3:0];
					rows_ok = 0;
				end
			end
			if (strobe) begin
				if (torque_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result: status %0d wheel %0d torque %0d",
							status, result_wheel, wheel_torque);
					fail_count <= fail_count + 1;
				end else begin
					e = torque_q.pop_front();
					if (status !== e.st || result_wheel !== e.wheel
							|| wheel_torque !== e.torque || clamped !== e.clip
							|| last !== e.fin) begin
						if (fail_count < 10)
							$display("mismatch: exp st %0d wh %0d tq %0d cl %0d last %0d, got st %0d wh %0d tq %0d cl %0d last %0d",
								e.st, e.wheel, e.torque, e.clip, e.fin,
								status, result_wheel, wheel_torque, clamped, last);
						fail_count <= fail_count + 1;
					end
				end
			end
			// The item is predicted after the result check so that a result
			// leaving in the same cycle is matched against older work first.
			if (start && !busy) predict_item();
		end
	end
endmodule

// File: tb/tb_top.sv
// Stimulus and verdict for the wheel torque allocator unit.
// Depends on wta_pkg, wheel_torque_allocator_unit and wta_checker.
`timescale 1ns / 1ps

module tb_top;
	import wta_pkg::*;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               start = 0;
	logic               busy;
	logic [1:0]         opcode = OP_LOAD;
	logic [2:0]         wheel_index = 0;
	logic signed [15:0] axis_x = 0;
	logic signed [15:0] axis_y = 0;
	logic signed [15:0] axis_z = 0;
	logic signed [23:0] torque_x = 0;
	logic signed [23:0] torque_y = 0;
	logic signed [23:0] torque_z = 0;
	logic               cfg_we = 0;
	logic [1:0]         cfg_index = REG_MAX_TORQUE;
	logic [22:0]        cfg_data = 0;
	logic               strobe;
	logic [1:0]         status;
	logic [2:0]         result_wheel;
	logic signed [23:0] wheel_torque;
	logic               clamped;
	logic               last;
	int                 fail_count;
	int                 pending;
	bit                 steady;

	wheel_torque_allocator_unit dut (.*);

	wta_checker chk (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("tb_top: errors");
		$finish;
	end

	task automatic send(logic [1:0] op, logic [2:0] idx, logic [15:0] ax, logic [15:0] ay,
			logic [15:0] az, logic [23:0] tx, logic [23:0] ty, logic [23:0] tz);
		if (!steady && $urandom_range(99) < 18) begin
			start <= 0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		opcode <= op;
		wheel_index <= idx;
		axis_x <= ax;
		axis_y <= ay;
		axis_z <= az;
		torque_x <= tx;
		torque_y <= ty;
		torque_z <= tz;
		start <= 1;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic load_axis(int idx, logic [15:0] ax, logic [15:0] ay, logic [15:0] az);
		send(OP_LOAD, 3'(idx), ax, ay, az, 24'($urandom), 24'($urandom), 24'($urandom));
	endtask

	task automatic allocate(logic [23:0] tx, logic [23:0] ty, logic [23:0] tz);
		send(OP_ALLOC, 3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), tx, ty, tz);
	endtask

	task automatic drain();
		start <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		// Every result owed has come back; idle on before going further.
		repeat (1000) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [22:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	function automatic logic [23:0] rand_torque();
		case ($urandom_range(3))
			0: return 24'($urandom);
			1: return 24'($signed($urandom_range(0, 400000)) - 200000);
			2: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
			default: return 24'($signed($urandom_range(0, 40000)) - 20000);
		endcase
	endfunction

	function automatic logic [15:0] rand_axis();
		if ($urandom_range(9) == 0) return 16'($signed($urandom_range(0, 8)) - 4);
		return 16'($urandom);
	endfunction

	initial begin
		int n;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Identity solution straight out of reset, with extreme torques.
		steady = 1;
		allocate(24'h7FFFFF, 24'h800000, 24'd0);
		allocate(24'd13107, 24'hFFCCCD, 24'd13108);
		allocate(24'd0, 24'd0, 24'hFFFFFF);
		send(2'd3, 3'd7, 16'h7FFF, 16'h8000, 16'hFFFF, 24'h7FFFFF, 24'h800000, 24'hFFFFFF);
		// A load makes the solution stale until the next build.
		load_axis(7, 16'h8000, 16'h7FFF, 16'h0000);
		allocate(24'd100, 24'd100, 24'd100);
		send(OP_BUILD, 0, 0, 0, 0, 0, 0, 0);
		allocate(24'd65536, 24'd1, 24'hFFFFFF);
		// A zero axis leaves the three wheels coplanar.
		load_axis(2, 16'd0, 16'd0, 16'd0);
		send(OP_BUILD, 0, 0, 0, 0, 0, 0, 0);
		allocate(24'd5, 24'd5, 24'd5);
		// Tiny axes round the matrix to zero, so the determinant is zero.
		load_axis(0, 16'd1, 16'd0, 16'd0);
		load_axis(1, 16'd0, 16'd1, 16'd0);
		load_axis(2, 16'd0, 16'd0, 16'hFFFF);
		send(OP_BUILD, 0, 0, 0, 0, 0, 0, 0);
		load_axis(0, 16'h7FFF, 16'h0000, 16'h0000);
		load_axis(1, 16'h0000, 16'h8000, 16'h0000);
		load_axis(2, 16'h0000, 16'h0000, 16'h4000);
		send(OP_BUILD, 0, 0, 0, 0, 0, 0, 0);
		allocate(24'h7FFFFF, 24'h7FFFFF, 24'h800000);
		drain();
		write_reg(REG_MAX_TORQUE, 23'h7FFFFF);
		write_reg(REG_WHEEL_COUNT, 23'd3);
		write_reg(2'd2, 23'h7FFFFF);
		write_reg(2'd3, 23'h000000);
		allocate(24'd1, 24'd1, 24'd1);
		send(OP_BUILD, 0, 0, 0, 0, 0, 0, 0);
		allocate(24'h7FFFFF, 24'h800000, 24'h7FFFFF);

		for (int ph = 0; ph < 8; ph++) begin
			drain();
			case (ph)
				0: write_reg(REG_MAX_TORQUE, 23'd0);
				1: write_reg(REG_MAX_TORQUE, 23'h7FFFFF);
				2: write_reg(REG_MAX_TORQUE, 23'd13107);
				default: write_reg(REG_MAX_TORQUE, 23'($urandom_range(0, 23'h7FFFFF)));
			endcase
			case (ph)
				0: write_reg(REG_WHEEL_COUNT, 23'd8);
				1: write_reg(REG_WHEEL_COUNT, 23'd0);
				2: write_reg(REG_WHEEL_COUNT, 23'd15);
				3: write_reg(REG_WHEEL_COUNT, 23'd1);
				default: write_reg(REG_WHEEL_COUNT, 23'($urandom_range(2, 9) | ($urandom << 4)));
			endcase
			steady = (ph == 2);
			n = (ph == 1 || ph == 3) ? 1 : (ph == 0 || ph == 2) ? 8 : 3;
			for (int k = 0; k < 2; k++) begin
				for (int i = 0; i < n; i++) load_axis(i, rand_axis(), rand_axis(), rand_axis());
				if ($urandom_range(3) == 0) allocate(rand_torque(), rand_torque(), rand_torque());
				send(OP_BUILD, 0, 0, 0, 0, 0, 0, 0);
				repeat ($urandom_range(2, 5)) allocate(rand_torque(), rand_torque(), rand_torque());
				if (k == 1 && ph == 4) begin
					// Hold the sender until everything owed has come back.
					start <= 0;
					@(posedge clk);
					while (pending != 0) @(posedge clk);
				end
				case ($urandom_range(3))
					0: send(2'd3, 3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
						24'($urandom), 24'($urandom), 24'($urandom));
					1: load_axis($urandom_range(7), rand_axis(), rand_axis(), rand_axis());
					default: ;
				endcase
			end
		end

		drain();
		if (fail_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end
endmodule
